### design/stok_pkg.sv
// Shared types and constants for the s-expression tokenizer.
`timescale 1ns / 1ps
package stok_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OUT_OFS_W = 16;
  localparam int MAX_TOK = 3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [3:0] {
    KIND_OPEN         = 4'd0,
    KIND_CLOSE        = 4'd1,
    KIND_DOT          = 4'd2,
    KIND_QUOTE        = 4'd3,
    KIND_BACKQUOTE    = 4'd4,
    KIND_COMMA        = 4'd5,
    KIND_STRING       = 4'd6,
    KIND_UNTERMINATED = 4'd7,
    KIND_SYMBOL       = 4'd8,
    KIND_END          = 4'd9
  } stok_kind_t;

  typedef struct packed {
    stok_kind_t           kind;
    logic [OUT_OFS_W-1:0] beg_ofs;
    logic [OUT_OFS_W-1:0] end_ofs;
  } stok_tok_t;

  typedef struct packed {
    logic [1:0]              count;
    stok_tok_t [MAX_TOK-1:0] tok;
  } stok_step_t;

endpackage

### design/stok_if.sv
// Request channels: source text bytes in, tokens out.
`timescale 1ns / 1ps
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] begin_offset;
  logic [15:0] end_offset;
  logic        last_of_run;

  modport source(output valid, token_kind, begin_offset, end_offset, last_of_run,
                 input ready);
  modport sink(input valid, token_kind, begin_offset, end_offset, last_of_run,
               output ready);
endinterface

### design/stok_scan.sv
// Scanner state and per-byte token decode.
`timescale 1ns / 1ps
module stok_scan #(
  parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_text,
  output stok_pkg::stok_step_t   res
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_SYMBOL  = 2'd3
  } mode_t;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] start, start_next;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   blank;
  logic                   sym_end;

  function automatic logic [stok_pkg::OUT_OFS_W-1:0] to_out(
    input logic [OFFSET_BITS-1:0] v
  );
    logic [OFFSET_BITS+stok_pkg::OUT_OFS_W-1:0] e;
    e = {{stok_pkg::OUT_OFS_W{1'b0}}, v};
    return e[stok_pkg::OUT_OFS_W-1:0];
  endfunction

  assign pos_inc = pos + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  assign blank   = (text_byte inside {8'h20, [8'h09:8'h0D]});
  assign sym_end = blank || (text_byte inside {stok_pkg::CH_OPEN, stok_pkg::CH_CLOSE,
                   stok_pkg::CH_DQUOTE, stok_pkg::CH_QUOTE, stok_pkg::CH_SEMI,
                   stok_pkg::CH_BTICK, stok_pkg::CH_COMMA});

  always_comb begin
    logic [1:0]           cnt;
    stok_pkg::stok_kind_t one_kind;
    logic                 one_hit;
    cnt        = 2'd0;
    res        = '0;
    mode_next  = mode;
    start_next = start;
    pos_next   = pos_inc;
    one_kind   = stok_pkg::KIND_OPEN;
    one_hit    = 1'b0;

    case (mode)
      MODE_COMMENT: begin
        if (text_byte == stok_pkg::CH_NL) mode_next = MODE_IDLE;
      end
      MODE_STRING: begin
        if (text_byte == stok_pkg::CH_DQUOTE) begin
          res.tok[cnt] = '{stok_pkg::KIND_STRING, to_out(start), to_out(pos_inc)};
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        if (mode == MODE_SYMBOL && sym_end) begin
          res.tok[cnt] = '{stok_pkg::KIND_SYMBOL, to_out(start), to_out(pos)};
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
        end
        if (mode_next == MODE_IDLE) begin
          case (text_byte)
            stok_pkg::CH_OPEN:  begin one_hit = 1'b1; one_kind = stok_pkg::KIND_OPEN; end
            stok_pkg::CH_CLOSE: begin one_hit = 1'b1; one_kind = stok_pkg::KIND_CLOSE; end
            stok_pkg::CH_DOT:   begin one_hit = 1'b1; one_kind = stok_pkg::KIND_DOT; end
            stok_pkg::CH_QUOTE: begin one_hit = 1'b1; one_kind = stok_pkg::KIND_QUOTE; end
            stok_pkg::CH_BTICK: begin
              one_hit = 1'b1;
              one_kind = stok_pkg::KIND_BACKQUOTE;
            end
            stok_pkg::CH_COMMA: begin one_hit = 1'b1; one_kind = stok_pkg::KIND_COMMA; end
            stok_pkg::CH_SEMI:  mode_next = MODE_COMMENT;
            stok_pkg::CH_DQUOTE: begin
              mode_next  = MODE_STRING;
              start_next = pos;
            end
            default: begin
              if (!blank) begin
                mode_next  = MODE_SYMBOL;
                start_next = pos;
              end
            end
          endcase
          if (one_hit) begin
            res.tok[cnt] = '{one_kind, to_out(pos), to_out(pos_inc)};
            cnt = cnt + 2'd1;
          end
        end
      end
    endcase

    if (end_of_text) begin
      if (mode_next == MODE_SYMBOL) begin
        res.tok[cnt] = '{stok_pkg::KIND_SYMBOL, to_out(start_next), to_out(pos_inc)};
        cnt = cnt + 2'd1;
      end else if (mode_next == MODE_STRING) begin
        res.tok[cnt] = '{stok_pkg::KIND_UNTERMINATED, to_out(start_next),
                         to_out(pos_inc)};
        cnt = cnt + 2'd1;
      end
      res.tok[cnt] = '{stok_pkg::KIND_END, to_out(pos_inc), to_out(pos_inc)};
      cnt = cnt + 2'd1;
      mode_next  = MODE_IDLE;
      pos_next   = '0;
      start_next = '0;
    end
    res.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      pos   <= '0;
      start <= '0;
    end else if (step) begin
      mode  <= mode_next;
      pos   <= pos_next;
      start <= start_next;
    end
  end

endmodule

### design/stok_outbuf.sv
// Result register: holds the tokens of one byte and hands them out in order.
`timescale 1ns / 1ps
module stok_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  stok_pkg::stok_step_t res,
  output logic                 free,
  stok_out_if.source           tokens
);

  stok_pkg::stok_tok_t [stok_pkg::MAX_TOK-1:0] slot;
  logic [1:0] count;
  logic [1:0] idx;
  logic       at_last;
  logic       fire;

  assign at_last = (idx == count - 2'd1);
  assign fire    = tokens.valid && tokens.ready;
  assign free    = (count == 2'd0) || (fire && at_last);

  assign tokens.valid        = (count != 2'd0);
  assign tokens.token_kind   = slot[idx].kind;
  assign tokens.begin_offset = slot[idx].beg_ofs;
  assign tokens.end_offset   = slot[idx].end_ofs;
  assign tokens.last_of_run  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      idx   <= 2'd0;
    end else if (load) begin
      count <= res.count;
      idx   <= 2'd0;
    end else if (fire) begin
      if (at_last) count <= 2'd0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot <= res.tok;
  end

endmodule

### design/sexpr_tokenizer_top.sv
// Top level of the s-expression tokenizer.
`timescale 1ns / 1ps
// Source text enters one byte per request on text and tokens leave one per request on
// tokens, each with its kind, begin and end offset, and last_of_run marking the final
// token caused by a byte. A byte is taken in every cycle as long as each byte yields at
// most one token and the token sink does not stall; a byte that yields k tokens (up to
// three, at the final byte) holds the result register while they drain. An accepted byte
// sits in the input register; its tokens load the result register once that is free,
// and the first of them is then offered on tokens.
// Offsets count modulo 2^OFFSET_BITS and the low 16 bits are reported; after the end
// token the next byte starts a new text at 0.
module sexpr_tokenizer_top #(
  parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  stok_in_if.sink    text,
  stok_out_if.source tokens
);

  logic                 in_vld;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic                 buf_free;
  logic                 advance;
  stok_pkg::stok_step_t step_res;

  assign advance    = in_vld && buf_free;
  assign text.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (text.ready) begin
      in_vld <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_byte <= text.text_byte;
      in_last <= text.end_of_text;
    end
  end

  stok_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .text_byte   (in_byte),
    .end_of_text (in_last),
    .res         (step_res)
  );

  stok_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .res    (step_res),
    .free   (buf_free),
    .tokens (tokens)
  );

endmodule

### design/stok_checker.sv
// Port-level assertions for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
module stok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [15:0] begin_offset,
  input logic [15:0] end_offset,
  input logic        last_of_run
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
    $stable(begin_offset) && $stable(end_offset))
    else $error("stalled token changed");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == stok_pkg::KIND_END |->
    last_of_run && begin_offset == end_offset)
    else $error("bad end token");

  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind <= stok_pkg::KIND_COMMA |->
    end_offset == begin_offset + 16'd1)
    else $error("single-byte token with wrong span");

endmodule

bind sexpr_tokenizer_top stok_checker u_stok_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.token_kind),
  .begin_offset (tokens.begin_offset),
  .end_offset   (tokens.end_offset),
  .last_of_run  (tokens.last_of_run)
);

### test/tb_sexpr_tokenizer_top.sv
// Testbench for sexpr_tokenizer_top: byte stream in, tokens checked against a local tokenizer.
`timescale 1ns / 1ps
module tb_sexpr_tokenizer_top;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int RANDOM_ITEMS = 430;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef enum logic [1:0] {
    SCAN_IDLE    = 2'd0,
    SCAN_COMMENT = 2'd1,
    SCAN_STRING  = 2'd2,
    SCAN_SYMBOL  = 2'd3
  } scan_state_t;

  typedef struct {
    stok_pkg::stok_kind_t kind;
    logic [15:0]          beg_ofs;
    logic [15:0]          end_ofs;
    logic                 last_tok;
  } token_exp_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;
  stok_in_if  text_ch ();
  stok_out_if token_ch ();

  sexpr_tokenizer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (token_ch)
  );

  token_exp_t  token_q[$];
  scan_state_t scan_mode;
  logic [15:0] scan_pos;
  logic [15:0] tok_start;
  int          fail_cnt;
  int          item_cnt;
  int          cycle_cnt;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_sexpr_tokenizer_top failed");
      $finish;
    end
  end

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit ends_symbol(input logic [7:0] b);
    return is_blank(b) || b == stok_pkg::CH_OPEN || b == stok_pkg::CH_CLOSE ||
           b == stok_pkg::CH_DQUOTE || b == stok_pkg::CH_QUOTE ||
           b == stok_pkg::CH_SEMI || b == stok_pkg::CH_BTICK || b == stok_pkg::CH_COMMA;
  endfunction

  task automatic push_token(input stok_pkg::stok_kind_t kind, input logic [15:0] b,
                            input logic [15:0] e);
    token_q.push_back('{kind, b, e, 1'b0});
  endtask

  // Expected tokens for one accepted byte.
  task automatic tokenize_byte(input logic [7:0] b, input logic eot);
    logic [15:0] p;
    logic [15:0] nxt;
    int          n;
    p = scan_pos;
    nxt = p + 16'd1;
    n = 0;
    case (scan_mode)
      SCAN_COMMENT: begin
        if (b == stok_pkg::CH_NL) scan_mode = SCAN_IDLE;
      end
      SCAN_STRING: begin
        if (b == stok_pkg::CH_DQUOTE) begin
          push_token(stok_pkg::KIND_STRING, tok_start, nxt);
          n++;
          scan_mode = SCAN_IDLE;
        end
      end
      default: begin
        if (scan_mode == SCAN_SYMBOL && ends_symbol(b)) begin
          push_token(stok_pkg::KIND_SYMBOL, tok_start, p);
          n++;
          scan_mode = SCAN_IDLE;
        end
        if (scan_mode == SCAN_IDLE) begin
          case (b)
            stok_pkg::CH_OPEN: begin push_token(stok_pkg::KIND_OPEN, p, nxt); n++; end
            stok_pkg::CH_CLOSE: begin push_token(stok_pkg::KIND_CLOSE, p, nxt); n++; end
            stok_pkg::CH_DOT: begin push_token(stok_pkg::KIND_DOT, p, nxt); n++; end
            stok_pkg::CH_QUOTE: begin push_token(stok_pkg::KIND_QUOTE, p, nxt); n++; end
            stok_pkg::CH_BTICK: begin
              push_token(stok_pkg::KIND_BACKQUOTE, p, nxt);
              n++;
            end
            stok_pkg::CH_COMMA: begin push_token(stok_pkg::KIND_COMMA, p, nxt); n++; end
            stok_pkg::CH_SEMI: scan_mode = SCAN_COMMENT;
            stok_pkg::CH_DQUOTE: begin
              scan_mode = SCAN_STRING;
              tok_start = p;
            end
            default: begin
              if (!is_blank(b)) begin
                scan_mode = SCAN_SYMBOL;
                tok_start = p;
              end
            end
          endcase
        end
      end
    endcase
    scan_pos = nxt;
    if (eot) begin
      if (scan_mode == SCAN_SYMBOL) begin
        push_token(stok_pkg::KIND_SYMBOL, tok_start, nxt);
        n++;
      end else if (scan_mode == SCAN_STRING) begin
        push_token(stok_pkg::KIND_UNTERMINATED, tok_start, nxt);
        n++;
      end
      push_token(stok_pkg::KIND_END, nxt, nxt);
      n++;
      scan_mode = SCAN_IDLE;
      scan_pos = '0;
      tok_start = '0;
    end
    if (n > 0) token_q[token_q.size()-1].last_tok = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      text_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid = 1'b1;
    text_ch.text_byte = b;
    text_ch.end_of_text = eot;
    do @(posedge clk); while (!text_ch.ready);
    tokenize_byte(b, eot);
    item_cnt++;
  endtask

  task automatic send_bytes(input byte_q_t bq, input bit eot_last);
    foreach (bq[i]) send_byte(bq[i], eot_last && i == bq.size() - 1);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    byte_q_t bq;
    for (int i = 0; i < s.len(); i++) bq.push_back(s[i]);
    send_bytes(bq, eot_last);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    text_ch.valid = 1'b0;
    while (token_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] symbol_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (ends_symbol(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
  endfunction

  // Text built from random tokens and stray bytes, sometimes cut short, sometimes plain noise.
  task automatic send_random_text();
    byte_q_t    bq;
    int         pieces;
    logic [7:0] b;
    logic [7:0] punct[6];
    punct = '{stok_pkg::CH_OPEN, stok_pkg::CH_CLOSE, stok_pkg::CH_DOT, stok_pkg::CH_QUOTE,
              stok_pkg::CH_BTICK, stok_pkg::CH_COMMA};
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 20)) bq.push_back(8'($urandom_range(0, 255)));
    end else begin
      pieces = $urandom_range(1, 12);
      repeat (pieces) begin
        case ($urandom_range(0, 9))
          0, 1: bq.push_back(punct[$urandom_range(0, 5)]);
          2, 3: repeat ($urandom_range(1, 6))
            bq.push_back(($urandom_range(0, 5) == 0) ? stok_pkg::CH_DOT : symbol_byte());
          4: begin
            bq.push_back(stok_pkg::CH_DQUOTE);
            repeat ($urandom_range(0, 5)) begin
              do b = 8'($urandom_range(0, 255)); while (b == stok_pkg::CH_DQUOTE);
              bq.push_back(b);
            end
            bq.push_back(stok_pkg::CH_DQUOTE);
          end
          5: begin
            bq.push_back(stok_pkg::CH_SEMI);
            repeat ($urandom_range(0, 5)) begin
              do b = 8'($urandom_range(0, 255)); while (b == stok_pkg::CH_NL);
              bq.push_back(b);
            end
            bq.push_back(stok_pkg::CH_NL);
          end
          6, 7: repeat ($urandom_range(1, 3)) bq.push_back(blank_byte());
          default: bq.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      if (bq.size() > 1 && $urandom_range(0, 3) == 0) void'(bq.pop_back());
    end
    send_bytes(bq, 1'b1);
  endtask

  task automatic test_punctuation();
    byte_q_t bq;
    bq = {stok_pkg::CH_OPEN, stok_pkg::CH_DOT, stok_pkg::CH_QUOTE, stok_pkg::CH_BTICK,
          stok_pkg::CH_COMMA, stok_pkg::CH_CLOSE};
    send_bytes(bq, 1'b0);
  endtask

  task automatic test_symbols_and_comments();
    byte_q_t bq;
    send_text("a.b;z\n", 1'b0);
    bq = {8'h00, CH_VT, 8'hFF, CH_FF, 8'h80, CH_CR, 8'h7F, CH_TAB};
    send_bytes(bq, 1'b0);
  endtask

  task automatic test_text_end();
    send_text("\"s", 1'b1);
    send_text("q", 1'b1);
    send_text(";c", 1'b1);
    send_text("a(", 1'b1);
    send_text("\"x\"", 1'b1);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_text("(k)", 1'b1);
  endtask

  task automatic test_random_texts();
    while (item_cnt < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_random_text();
    end
    idle_on = 1'b1;
  endtask

  // Result sink with random stalls.
  initial begin
    int gap;
    token_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        token_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      token_ch.ready = 1'b1;
      do @(posedge clk); while (!token_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_tokens
    token_exp_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (token_q.size() == 0) begin
        $error("unexpected token: kind %0d begin %0d end %0d", token_ch.token_kind,
               token_ch.begin_offset, token_ch.end_offset);
        fail_cnt++;
      end else begin
        want = token_q.pop_front();
        if (token_ch.token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, token_ch.token_kind);
          fail_cnt++;
        end
        if (token_ch.begin_offset !== want.beg_ofs) begin
          $error("begin_offset: expected %0d, got %0d", want.beg_ofs, token_ch.begin_offset);
          fail_cnt++;
        end
        if (token_ch.end_offset !== want.end_ofs) begin
          $error("end_offset: expected %0d, got %0d", want.end_ofs, token_ch.end_offset);
          fail_cnt++;
        end
        if (token_ch.last_of_run !== want.last_tok) begin
          $error("last_of_run: expected %0d, got %0d", want.last_tok, token_ch.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.end_of_text = 1'b0;
    scan_mode = SCAN_IDLE;
    scan_pos = '0;
    tok_start = '0;
    fail_cnt = 0;
    item_cnt = 0;
    cycle_cnt = 0;
    idle_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_punctuation();
    test_symbols_and_comments();
    test_text_end();
    test_drain_pause();
    test_random_texts();

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_sexpr_tokenizer_top passed");
    end else begin
      $display("tb_sexpr_tokenizer_top failed");
    end
    $finish;
  end

endmodule
